/* design/upd_pkg.sv */
`timescale 1ns / 1ps

package upd_pkg;

   localparam int UNIT_W = 16;
   localparam int BYTE_W = 8;

   localparam logic [UNIT_W-1:0] PCT_CHAR = 16'h0025;

   // Byte class boundaries of UTF-8.
   localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
   localparam logic [BYTE_W-1:0] CONT_MAX  = 8'hBF;
   localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
   localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;

   typedef enum logic [1:0] {
      ESC_IDLE  = 2'd0,
      ESC_PCT   = 2'd1,
      ESC_DIGIT = 2'd2
   } esc_phase_type;

   typedef enum logic [1:0] {
      SEQ_NONE  = 2'd0,
      SEQ_ONE   = 2'd1,
      SEQ_TWO   = 2'd2,
      SEQ_STRAY = 2'd3
   } seq_state_type;

   // One queued command: one or two decoded units for one input word.
   typedef struct packed {
      logic              two_units;
      logic [UNIT_W-1:0] unit0;
      logic [UNIT_W-1:0] unit1;
   } cmd_type;

   // Returns {is_hex, value}; only ASCII 0-9, A-F, a-f are hex digits.
   function automatic logic [4:0] hex_digit(input logic [UNIT_W-1:0] u);
      logic [4:0] r;
      r = 5'd0;
      if (u >= 16'h0030 && u <= 16'h0039) begin
         r = {1'b1, 4'(u - 16'h0030)};
      end else if (u >= 16'h0041 && u <= 16'h0046) begin
         r = {1'b1, 4'(u - 16'h0041 + 16'd10)};
      end else if (u >= 16'h0061 && u <= 16'h0066) begin
         r = {1'b1, 4'(u - 16'h0061 + 16'd10)};
      end
      return r;
   endfunction

endpackage

/* design/upd_front.sv */
`timescale 1ns / 1ps

module upd_front
   import upd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [UNIT_W-1:0] char_in,
   input  logic              is_final,
   output logic              push,
   output cmd_type           cmd
);

   esc_phase_type     phase_ff, phase_in;
   logic [4:0]        held_ff, held_in;
   seq_state_type     seq_ff, seq_in;
   logic [UNIT_W-1:0] acc_ff, acc_in;

   logic [4:0]        hex_c;
   logic [BYTE_W-1:0] byte_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ESC_IDLE;
         held_ff  <= 5'd0;
         seq_ff   <= SEQ_NONE;
         acc_ff   <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
         seq_ff   <= seq_in;
         acc_ff   <= acc_in;
      end
   end

   always_comb begin
      hex_c    = hex_digit(char_in);
      phase_in = phase_ff;
      held_in  = held_ff;
      seq_in   = seq_ff;
      acc_in   = acc_ff;
      push     = 1'b0;
      cmd      = '{two_units: 1'b0, unit0: char_in, unit1: char_in};
      byte_val = '0;

      unique case (phase_ff)
         ESC_PCT: begin
            if (is_final) begin
               push          = 1'b1;
               cmd.two_units = 1'b1;
               cmd.unit0     = PCT_CHAR;
            end else begin
               held_in  = hex_c;
               phase_in = ESC_DIGIT;
            end
         end
         ESC_DIGIT: begin
            // A non-hex second digit leaves the first digit as the byte.
            if (held_ff[4]) begin
               byte_val = hex_c[4] ? {held_ff[3:0], hex_c[3:0]} : {4'd0, held_ff[3:0]};
            end
            phase_in = ESC_IDLE;
            held_in  = 5'd0;
            cmd.unit0 = {8'd0, byte_val};
            if (byte_val <= ASCII_MAX) begin
               push = 1'b1;
            end else if (byte_val <= CONT_MAX) begin
               unique case (seq_ff)
                  SEQ_TWO: begin
                     acc_in = acc_ff | {4'd0, byte_val[5:0], 6'd0};
                     seq_in = SEQ_ONE;
                  end
                  SEQ_ONE: begin
                     acc_in    = acc_ff | {10'd0, byte_val[5:0]};
                     seq_in    = SEQ_NONE;
                     push      = 1'b1;
                     cmd.unit0 = acc_in;
                  end
                  default: begin
                     acc_in = acc_ff | {10'd0, byte_val[5:0]};
                     seq_in = SEQ_STRAY;
                  end
               endcase
            end else if (byte_val <= LEAD2_MAX) begin
               acc_in = {5'd0, byte_val[4:0], 6'd0};
               seq_in = SEQ_ONE;
            end else if (byte_val <= LEAD3_MAX) begin
               acc_in = {byte_val[3:0], 12'd0};
               seq_in = SEQ_TWO;
            end
         end
         default: begin
            phase_in = ESC_IDLE;
            if (char_in == PCT_CHAR && !is_final) begin
               phase_in = ESC_PCT;
            end else begin
               push = 1'b1;
            end
         end
      endcase

      // The end of a text returns all decode state to its reset value.
      if (is_final) begin
         phase_in = ESC_IDLE;
         held_in  = 5'd0;
         seq_in   = SEQ_NONE;
         acc_in   = '0;
      end
   end

endmodule

/* design/upd_queue.sv */
`timescale 1ns / 1ps

module upd_queue
   import upd_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* design/upd_back.sv */
`timescale 1ns / 1ps

module upd_back
   import upd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              empty,
   input  cmd_type           head,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [UNIT_W-1:0] rsp_tdata,
   output logic              rsp_tlast
);

   logic              valid_ff, valid_in;
   logic              second_ff, second_in;
   logic [UNIT_W-1:0] data_ff, data_in;
   logic              last_ff, last_in;
   logic              load;

   assign load       = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   always_comb begin
      valid_in  = valid_ff && !rsp_tready;
      second_in = second_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      pop       = 1'b0;
      if (load && !empty) begin
         valid_in = 1'b1;
         if (second_ff) begin
            data_in   = head.unit1;
            last_in   = 1'b1;
            second_in = 1'b0;
            pop       = 1'b1;
         end else if (head.two_units) begin
            data_in   = head.unit0;
            last_in   = 1'b0;
            second_in = 1'b1;
         end else begin
            data_in = head.unit0;
            last_in = 1'b1;
            pop     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

endmodule

/* design/url_percent_decoder_utf8_unit.sv */
// Streaming URL percent decoder. Each input word is one 16-bit code unit of
// the encoded text, with tlast marking the last unit of a text. A '%' and the
// two units after it are read as a hex byte (a non-hex first digit gives 0, a
// non-hex second digit leaves the first digit alone); bytes up to 0x7F come
// out as code units, two- and three-byte UTF-8 sequences are assembled into
// one 16-bit unit, bytes 0xF0 and above are dropped, and every other unit
// passes unchanged. An input word yields zero, one or two output words, and
// rsp_tlast marks the last output word of each input word. Each input word is
// decoded combinationally in the front stage, which can accept a word every
// cycle while the command queue has room; the output stage delivers one word
// per cycle while rsp_tready is high, so a sustained rate of one input word per
// cycle holds except where an input word yields two output words, which
// occupy the output register one after the other.
`timescale 1ns / 1ps

module url_percent_decoder_utf8_unit
   import upd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [UNIT_W-1:0] req_tdata,   // [15:0] char_in
   input  logic              req_tlast,   // is_final
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [UNIT_W-1:0] rsp_tdata,   // [15:0] char_out
   output logic              rsp_tlast    // run_last
);

   logic    take;
   logic    push;
   cmd_type cmd;
   logic    pop;
   logic    full;
   logic    empty;
   cmd_type head;

   // The front stage stalls only when the queue has no room for a command.
   assign req_tready = !full;
   assign take       = req_tvalid && req_tready;

   upd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .char_in  (req_tdata),
      .is_final (req_tlast),
      .push     (push),
      .cmd      (cmd)
   );

   // Words that produce no output never enter the queue.
   upd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (take && push),
      .push_cmd (cmd),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   upd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* tb/tb_url_percent_decoder_utf8_unit.sv */
`timescale 1ns / 1ps

module tb_url_percent_decoder_utf8_unit;
   import upd_pkg::*;

   // One input word as it is queued for the driver: a code unit of the
   // encoded text and the flag that marks the last unit of a text.
   typedef struct {
      logic [UNIT_W-1:0] unit;
      logic              ends_text;
   } text_word_type;

   // One decoded unit as it is expected on the output side.
   typedef struct {
      logic [UNIT_W-1:0] unit;
      logic              last_of_word;
   } decoded_unit_type;

   localparam int RANDOM_WORDS = 1250;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;

   // Units that sit right beside the hex digit ranges, or that carry a hex
   // digit in the low byte with upper bits set, and 0xFF10. None of them is a hex digit.
   localparam logic [UNIT_W-1:0] NEAR_MISS [10] = '{
      16'h002F, 16'h003A, 16'h0040, 16'h0047, 16'h0060,
      16'h0067, 16'h0130, 16'h0141, 16'h0161, 16'hFF10
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [UNIT_W-1:0] req_tdata = '0;   // [15:0] char_in
   logic              req_tlast = 1'b0; // is_final
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [UNIT_W-1:0] rsp_tdata;        // [15:0] char_out
   logic              rsp_tlast;        // run_last

   text_word_type    pending_words[$];
   decoded_unit_type expected_units[$];
   int               error_count = 0;
   int               cycle_count = 0;
   logic             calm;

   // Shadow of the decoder state, kept in step with every accepted word.
   esc_phase_type     esc_state   = ESC_IDLE;
   logic [4:0]        first_digit = '0;
   seq_state_type     seq_state   = SEQ_NONE;
   logic [UNIT_W-1:0] accum       = '0;

   url_percent_decoder_utf8_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // A window in the middle of the run where neither side ever idles, so
   // the decoder also sees long back-to-back bursts.
   assign calm = (cycle_count >= 300) && (cycle_count < 800);

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Returns {is_hex, value}. Only ASCII 0-9, A-F and a-f count as digits.
   function automatic logic [4:0] read_hex(input logic [UNIT_W-1:0] u);
      if (u >= 16'h0030 && u <= 16'h0039) return {1'b1, u[3:0]};
      if ((u >= 16'h0041 && u <= 16'h0046) || (u >= 16'h0061 && u <= 16'h0066))
         return {1'b1, 4'(u[3:0] + 4'd9)};
      return 5'd0;
   endfunction

   // Feeds one decoded byte into the UTF-8 assembly. A byte up to 0x7F is a
   // unit by itself; lead bytes open a sequence, continuation bytes fill the
   // accumulator, and bytes 0xF0 and above vanish.
   task automatic absorb_byte(input logic [7:0] b, output logic emit,
                              output logic [UNIT_W-1:0] unit);
      emit = 1'b0;
      unit = '0;
      if (b <= ASCII_MAX) begin
         emit = 1'b1;
         unit = {8'h00, b};
      end else if (b <= CONT_MAX) begin
         case (seq_state)
            SEQ_TWO: begin
               accum     = accum | {4'h0, b[5:0], 6'h00};
               seq_state = SEQ_ONE;
            end
            SEQ_ONE: begin
               accum     = accum | {10'h000, b[5:0]};
               seq_state = SEQ_NONE;
               emit      = 1'b1;
               unit      = accum;
            end
            default: begin
               // A continuation byte with no sequence open. Its bits still
               // land in the accumulator, but the next lead byte overwrites
               // them before anything can be emitted.
               accum     = accum | {10'h000, b[5:0]};
               seq_state = SEQ_STRAY;
            end
         endcase
      end else if (b <= LEAD2_MAX) begin
         accum     = {5'h00, b[4:0], 6'h00};
         seq_state = SEQ_ONE;
      end else if (b <= LEAD3_MAX) begin
         accum     = {b[3:0], 12'h000};
         seq_state = SEQ_TWO;
      end
   endtask

   // Works out the output words that one accepted input word causes and
   // appends them to the expected store.
   task automatic decode_word(input logic [UNIT_W-1:0] unit, input logic ends_text);
      logic [UNIT_W-1:0] outs [2];
      logic [UNIT_W-1:0] assembled;
      logic [4:0]        second_digit;
      logic [7:0]        b;
      logic              emit;
      int                n;
      n = 0;
      case (esc_state)
         ESC_PCT: begin
            if (ends_text) begin
               // The text ends one unit after the percent sign: both pass
               // through literally.
               outs[0] = PCT_CHAR;
               outs[1] = unit;
               n = 2;
            end else begin
               first_digit = read_hex(unit);
               esc_state   = ESC_DIGIT;
            end
         end
         ESC_DIGIT: begin
            // A non-hex first digit makes the byte zero; a non-hex second
            // digit leaves the first digit as the whole byte.
            b = 8'h00;
            if (first_digit[4]) begin
               second_digit = read_hex(unit);
               b = second_digit[4] ? {first_digit[3:0], second_digit[3:0]}
                                   : {4'h0, first_digit[3:0]};
            end
            esc_state   = ESC_IDLE;
            first_digit = '0;
            absorb_byte(b, emit, assembled);
            if (emit) begin
               outs[0] = assembled;
               n = 1;
            end
         end
         default: begin
            esc_state = ESC_IDLE;
            if (unit == PCT_CHAR && !ends_text) begin
               esc_state = ESC_PCT;
            end else begin
               outs[0] = unit;
               n = 1;
            end
         end
      endcase
      for (int k = 0; k < n; k++) begin
         expected_units.push_back('{unit: outs[k], last_of_word: (k == n - 1)});
      end
      if (ends_text) begin
         esc_state   = ESC_IDLE;
         first_digit = '0;
         seq_state   = SEQ_NONE;
         accum       = '0;
      end
   endtask

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t ns: %s", $time, msg);
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   task automatic push_word(input logic [UNIT_W-1:0] unit, input logic ends_text = 1'b0);
      pending_words.push_back('{unit: unit, ends_text: ends_text});
   endtask

   // Hex digit as a code unit, letters in random case.
   function automatic logic [UNIT_W-1:0] hex_char(input logic [3:0] nib);
      if (nib < 4'd10) return 16'h0030 + UNIT_W'(nib);
      return ($urandom_range(0, 1) ? 16'h0041 : 16'h0061) + UNIT_W'(nib) - 16'd10;
   endfunction

   // A well-formed escape of one byte: percent sign and two hex digits.
   task automatic push_escaped_byte(input logic [7:0] b);
      push_word(PCT_CHAR);
      push_word(hex_char(b[7:4]));
      push_word(hex_char(b[3:0]));
   endtask

   // Something that may or may not be a hex digit, for malformed escapes.
   function automatic logic [UNIT_W-1:0] any_digit_unit();
      case ($urandom_range(0, 5))
         3:       return NEAR_MISS[$urandom_range(0, 9)];
         4:       return UNIT_W'($urandom_range(0, 16'hFFFF));
         5:       return PCT_CHAR;
         default: return hex_char(4'($urandom_range(0, 15)));
      endcase
   endfunction

   // Marks the most recent word as the end of its text.
   task automatic end_text();
      if (pending_words.size() != 0) begin
         pending_words[pending_words.size() - 1].ends_text = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver: presents queued words on the input side. A new word is put up
   // only once the previous one has been taken; outside the calm window a random
   // idle drops tvalid with a chance of about eleven in a hundred.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      text_word_type next_word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= 11)) begin
            next_word   = pending_words.pop_front();
            req_tdata  <= next_word.unit;
            req_tlast  <= next_word.ends_text;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: every word taken on the input side goes through the
   // predictor, and every word delivered on the output side is checked
   // against the oldest expectation. The output side stalls at random too.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_ports
      decoded_unit_type oldest;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_word(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_units.size() == 0) begin
               flag_error($sformatf("output word 0x%04h last=%0b with nothing expected",
                                    rsp_tdata, rsp_tlast));
            end else begin
               oldest = expected_units.pop_front();
               if (rsp_tdata !== oldest.unit) begin
                  flag_error($sformatf("char_out mismatch: expected 0x%04h, got 0x%04h",
                                       oldest.unit, rsp_tdata));
               end
               if (rsp_tlast !== oldest.last_of_word) begin
                  flag_error($sformatf("run_last mismatch on 0x%04h: expected %0b, got %0b",
                                       oldest.unit, oldest.last_of_word, rsp_tlast));
               end
            end
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= 11);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_url_percent_decoder_utf8_unit failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      int                pick;
      int                target;
      logic [UNIT_W-1:0] cp;

      // Extremes of the unit passing straight through.
      push_word(16'h0000);
      push_word(16'hFFFF);
      // Second digit not hex: the byte is the first digit alone.
      push_word(PCT_CHAR); push_word(16'h0034); push_word(16'h007A);
      // First digit not hex: the byte is zero.
      push_word(PCT_CHAR); push_word(16'h0047); push_word(16'h0037);
      // Two-byte sequence, mixed case, decodes to 0x00E9.
      push_word(PCT_CHAR); push_word(16'h0063); push_word(16'h0033);
      push_word(PCT_CHAR); push_word(16'h0041); push_word(16'h0039);
      // Stray continuation byte, then a byte of the ignored range.
      push_word(PCT_CHAR); push_word(16'h0039); push_word(16'h0066);
      push_word(PCT_CHAR); push_word(16'h0046); push_word(16'h0030);
      // A percent sign that ends the text comes out literally.
      push_word(PCT_CHAR, 1'b1);
      // A percent sign followed by the last unit: both come out literally.
      push_word(PCT_CHAR);
      push_word(16'hFFFF, 1'b1);

      target = pending_words.size() + RANDOM_WORDS;
      while (pending_words.size() < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // Well-formed escaped character of one, two or three bytes.
            cp = UNIT_W'($urandom_range(0, 16'hFFFF));
            case ($urandom_range(0, 2))
               0: push_escaped_byte({1'b0, cp[6:0]});
               1: begin
                  push_escaped_byte({3'b110, cp[10:6]});
                  push_escaped_byte({2'b10, cp[5:0]});
               end
               default: begin
                  push_escaped_byte({4'b1110, cp[15:12]});
                  push_escaped_byte({2'b10, cp[11:6]});
                  push_escaped_byte({2'b10, cp[5:0]});
               end
            endcase
         end else if (pick < 62) begin
            // Plain units: printable ASCII or anything at all.
            if ($urandom_range(0, 1)) push_word(UNIT_W'($urandom_range(16'h20, 16'h7E)));
            else push_word(UNIT_W'($urandom_range(0, 16'hFFFF)));
         end else if (pick < 74) begin
            // Escape with arbitrary, often malformed, digits.
            push_word(PCT_CHAR);
            push_word(any_digit_unit());
            push_word(any_digit_unit());
         end else if (pick < 86) begin
            // Broken UTF-8: cut-off sequences, stray continuations and
            // bytes of the ignored range.
            case ($urandom_range(0, 3))
               0: repeat ($urandom_range(1, 3))
                     push_escaped_byte(8'(8'h80 + $urandom_range(0, 8'h3F)));
               1: begin
                  push_escaped_byte(8'(8'hE0 + $urandom_range(0, 8'h0F)));
                  push_escaped_byte(8'(8'h80 + $urandom_range(0, 8'h3F)));
               end
               2: push_escaped_byte(8'(8'hF0 + $urandom_range(0, 8'h0F)));
               default: push_escaped_byte(8'($urandom_range(0, 255)));
            endcase
         end else if (pick < 92) begin
            // Escape cut short by the end of the text.
            push_word(PCT_CHAR);
            if ($urandom_range(0, 1)) push_word(any_digit_unit());
            end_text();
         end else begin
            end_text();
         end
      end
      end_text();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Wait for the driver to hand over every word, then for the decoder
      // to deliver every expected word, then a short drain for strays.
      while (pending_words.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_units.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_units.size() == 0) begin
         $display("tb_url_percent_decoder_utf8_unit passed");
      end else begin
         $display("tb_url_percent_decoder_utf8_unit failed");
      end
      $finish;
   end

endmodule
